// ===== design/mftt_pkg.sv =====
package mftt_pkg;

  localparam int COUNTS_PER_TURN = 8192;
  localparam int CPT_LOG2        = $clog2(COUNTS_PER_TURN);

  localparam int FRAME_W  = 56;
  localparam int ANGLE_W  = 16;
  localparam int SPEED_W  = 16;
  localparam int CURR_W   = 16;
  localparam int TEMP_W   = 8;
  localparam int OFFSET_W = 13;
  localparam int TURNS_W  = 24;
  localparam int TOTAL_W  = 38;
  localparam int REL_W    = 16;
  localparam int DEG_W    = 20;

  // Degrees in 1/256 units per full turn.
  localparam int DEG_SCALE = 360 * 256;
  localparam int PROD_W    = 34;

  localparam int QUEUE_DEPTH = 2;

  // APB register map: one 32-bit register per word.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_ZERO_OFFSET = 1'b0;

  // Turn step decided by the front part for each frame.
  localparam logic [1:0] STEP_HOLD = 2'd0;
  localparam logic [1:0] STEP_DOWN = 2'd1;
  localparam logic [1:0] STEP_UP   = 2'd2;

  typedef struct packed {
    logic        [ANGLE_W-1:0] angle;
    logic signed [SPEED_W-1:0] speed;
    logic signed [CURR_W-1:0]  current;
    logic        [TEMP_W-1:0]  temperature;
    logic        [1:0]         step;
  } entry_t;

endpackage

// ===== design/motor_feedback_turn_tracker.sv =====
// Motor feedback turn tracker. Each 7-byte feedback word is unpacked into
// angle, speed, current and temperature, and the angle is compared with that
// of the previous word to keep a saturating count of whole turns; the result
// word also carries the multi-turn position and the angle from the zero
// offset in counts and in degrees (1/256 units). One word is accepted every
// clock cycle while the queue is not full. An accepted word is written into
// the queue, and its result is loaded into the output register once that
// register is empty or its result is being taken. The front part decides the
// turn step and writes a two-entry queue, and the back part updates the turn
// count and loads the output register, so a stall on the result side only
// holds off input once the queue is full. The previous angle starts at zero
// after reset, so the first word may count a turn. The zero offset is
// register 0 of the APB port and should be written while idle.
module motor_feedback_turn_tracker
  import mftt_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic        [ADDR_W-1:0]  paddr,
  input  logic        [DATA_W-1:0]  pwdata,
  output logic        [DATA_W-1:0]  prdata,
  output logic                      pready,
  input  logic        [FRAME_W-1:0] frame_bytes,
  input  logic                      frame_valid,
  output logic                      frame_ready,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic        [ANGLE_W-1:0] rotor_angle,
  output logic signed [SPEED_W-1:0] rotor_speed,
  output logic signed [CURR_W-1:0]  torque_current,
  output logic        [TEMP_W-1:0]  motor_temperature,
  output logic signed [TURNS_W-1:0] turns,
  output logic signed [TOTAL_W-1:0] total_position,
  output logic signed [REL_W-1:0]   relative_counts,
  output logic signed [DEG_W-1:0]   relative_degrees_q8
);

  logic [OFFSET_W-1:0] zero_offset;
  logic                offset_sel;
  logic                queue_full;
  logic                queue_not_empty;
  logic                push;
  logic                pop;
  entry_t              push_entry;
  entry_t              head;

  assign pready     = 1'b1;
  assign offset_sel = (paddr[ADDR_W-1:2] == REG_ZERO_OFFSET);
  assign prdata     = offset_sel ? DATA_W'(zero_offset) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= '0;
    end else if (psel && penable && pwrite && pready && offset_sel) begin
      zero_offset <= pwdata[OFFSET_W-1:0];
    end
  end

  mftt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .queue_full  (queue_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  mftt_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  mftt_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .zero_offset         (zero_offset),
    .queue_not_empty     (queue_not_empty),
    .head                (head),
    .pop                 (pop),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .rotor_angle         (rotor_angle),
    .rotor_speed         (rotor_speed),
    .torque_current      (torque_current),
    .motor_temperature   (motor_temperature),
    .turns               (turns),
    .total_position      (total_position),
    .relative_counts     (relative_counts),
    .relative_degrees_q8 (relative_degrees_q8)
  );

endmodule

// ===== design/mftt_front.sv =====
module mftt_front
  import mftt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [FRAME_W-1:0] frame_bytes,
  input  logic               frame_valid,
  output logic               frame_ready,
  input  logic               queue_full,
  output logic               push,
  output entry_t             push_entry
);

  logic        [ANGLE_W-1:0] prev_angle;
  logic        [ANGLE_W-1:0] angle;
  logic signed [ANGLE_W:0]   delta;

  localparam logic signed [ANGLE_W:0] HALF_S = (ANGLE_W + 1)'(COUNTS_PER_TURN / 2);

  assign frame_ready = !queue_full;
  assign push        = frame_valid && frame_ready;
  assign angle       = frame_bytes[55:40];
  assign delta       = signed'({1'b0, angle}) - signed'({1'b0, prev_angle});

  always_comb begin
    push_entry.angle       = angle;
    push_entry.speed       = signed'(frame_bytes[39:24]);
    push_entry.current     = signed'(frame_bytes[23:8]);
    push_entry.temperature = frame_bytes[7:0];
    // A large forward jump means the encoder wrapped backwards, and vice versa.
    priority if (delta > HALF_S) begin
      push_entry.step = STEP_DOWN;
    end else if (delta < -HALF_S) begin
      push_entry.step = STEP_UP;
    end else begin
      push_entry.step = STEP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_angle <= '0;
    end else if (push) begin
      prev_angle <= angle;
    end
  end

endmodule

// ===== design/mftt_queue.sv =====
module mftt_queue
  import mftt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/mftt_back.sv =====
module mftt_back
  import mftt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic        [OFFSET_W-1:0] zero_offset,
  input  logic                       queue_not_empty,
  input  entry_t                     head,
  output logic                       pop,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic        [ANGLE_W-1:0]  rotor_angle,
  output logic signed [SPEED_W-1:0]  rotor_speed,
  output logic signed [CURR_W-1:0]   torque_current,
  output logic        [TEMP_W-1:0]   motor_temperature,
  output logic signed [TURNS_W-1:0]  turns,
  output logic signed [TOTAL_W-1:0]  total_position,
  output logic signed [REL_W-1:0]    relative_counts,
  output logic signed [DEG_W-1:0]    relative_degrees_q8
);

  localparam int WORK_W = ANGLE_W + 2;
  localparam logic signed [WORK_W-1:0] HALF_S = WORK_W'(COUNTS_PER_TURN / 2);
  localparam logic signed [WORK_W-1:0] FULL_S = WORK_W'(COUNTS_PER_TURN);
  localparam logic signed [TURNS_W-1:0] TURN_MAX = {1'b0, {(TURNS_W - 1){1'b1}}};
  localparam logic signed [TURNS_W-1:0] TURN_MIN = {1'b1, {(TURNS_W - 1){1'b0}}};

  logic signed [TURNS_W-1:0] turn_count;
  logic signed [TURNS_W-1:0] turn_count_next;
  logic signed [WORK_W-1:0]  ang_s;
  logic signed [WORK_W-1:0]  off_s;
  logic signed [WORK_W-1:0]  diff;
  logic signed [WORK_W-1:0]  rel;
  logic signed [REL_W-1:0]   rel16;
  logic signed [TOTAL_W-1:0] total;
  logic signed [PROD_W-1:0]  deg_prod;
  logic signed [PROD_W-1:0]  deg_shift;

  assign pop = queue_not_empty && (!result_valid || result_ready);

  always_comb begin
    turn_count_next = turn_count;
    unique case (head.step)
      STEP_DOWN: begin
        if (turn_count != TURN_MIN) begin
          turn_count_next = turn_count - 1'b1;
        end
      end
      STEP_UP: begin
        if (turn_count != TURN_MAX) begin
          turn_count_next = turn_count + 1'b1;
        end
      end
      STEP_HOLD: turn_count_next = turn_count;
      default:   turn_count_next = turn_count;
    endcase
  end

  assign ang_s = signed'({2'b00, head.angle});
  assign off_s = signed'({(WORK_W - OFFSET_W)'(0), zero_offset});
  assign diff  = ang_s - off_s;

  // Move the angle by one turn where needed so that it lies within half a turn
  // of the offset.
  always_comb begin
    if (off_s >= HALF_S) begin
      rel = (ang_s > off_s - HALF_S) ? diff : diff + FULL_S;
    end else begin
      rel = (ang_s > off_s + HALF_S) ? diff - FULL_S : diff;
    end
  end

  assign rel16     = rel[REL_W-1:0];
  assign total     = (TOTAL_W'(turn_count_next) <<< CPT_LOG2) + TOTAL_W'(diff);
  assign deg_prod  = PROD_W'(rel16) * PROD_W'(DEG_SCALE);
  // The arithmetic shift rounds towards minus infinity.
  assign deg_shift = deg_prod >>> CPT_LOG2;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        turn_count   <= turn_count_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rotor_angle         <= head.angle;
      rotor_speed         <= head.speed;
      torque_current      <= head.current;
      motor_temperature   <= head.temperature;
      turns               <= turn_count_next;
      total_position      <= total;
      relative_counts     <= rel16;
      relative_degrees_q8 <= deg_shift[DEG_W-1:0];
    end
  end

endmodule

// ===== design/mftt_checker.sv =====
module mftt_checker
  import mftt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic        [ANGLE_W-1:0] rotor_angle,
  input  logic signed [TURNS_W-1:0] turns,
  input  logic signed [TOTAL_W-1:0] total_position,
  input  logic signed [REL_W-1:0]   relative_counts,
  input  logic signed [DEG_W-1:0]   relative_degrees_q8
);

  localparam int REST_W = TOTAL_W + 2;
  localparam logic signed [REST_W-1:0] OFFSET_LIMIT = REST_W'((1 << OFFSET_W) - 1);

  logic signed [PROD_W-1:0] deg_prod;
  logic signed [PROD_W-1:0] deg_shift;
  logic signed [REST_W-1:0] pos_rest;

  assign deg_prod  = PROD_W'(relative_counts) * PROD_W'(DEG_SCALE);
  assign deg_shift = deg_prod >>> CPT_LOG2;
  // What is left of the position once turns and angle are taken out is minus
  // the offset.
  assign pos_rest  = REST_W'(total_position) - (REST_W'(turns) <<< CPT_LOG2)
                     - signed'({(REST_W - ANGLE_W)'(0), rotor_angle});

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(turns)
      && $stable(total_position) && $stable(rotor_angle))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_degrees: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> relative_degrees_q8 == deg_shift[DEG_W-1:0])
    else $error("degrees do not follow the relative counts");

  a_position_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> total_position[CPT_LOG2-1:0] == relative_counts[CPT_LOG2-1:0])
    else $error("position and relative counts disagree within a turn");

  a_position_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pos_rest <= 0 && pos_rest >= -OFFSET_LIMIT)
    else $error("position does not match turns and angle");

endmodule

bind motor_feedback_turn_tracker mftt_checker u_mftt_checker (.*);
